@@ design/hth_pkg.sv @@
// ----------------------------------------------------------------------------
// hth_pkg
// Types, register indexes and code tables for the Hamming-weight tuple
// histogram.
// ----------------------------------------------------------------------------
package hth_pkg;

	typedef struct packed {
		logic        op;
		logic [63:0] sample;
		logic [17:0] bin_index;
	} hth_in_t;

	typedef struct packed {
		logic [39:0] bin_count;
		logic [17:0] bin_echo;
	} hth_out_t;

	localparam int CFG_INDEX_BITS = 8;
	localparam int CFG_DATA_BITS  = 8;

	localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_MODE = 8'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WORD_SIZE   = 8'd1;

	localparam logic OP_FEED = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [1:0] MODE_WORD   = 2'd0;
	localparam logic [1:0] MODE_BYTES  = 2'd1;
	localparam logic [1:0] MODE_LOW    = 2'd2;
	localparam logic [1:0] MODE_GATHER = 2'd3;

	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_WORD  = 2'd1,
		KIND_BYTES = 2'd2
	} hth_kind_t;

	function automatic logic [3:0] popcount8(input logic [7:0] b);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			n = n + {3'b000, b[i]};
		end
		return n;
	endfunction

	function automatic logic [1:0] byte_code(input logic [3:0] w);
		logic [1:0] c;
		case (w)
			4'd0, 4'd1: c = 2'd0;
			4'd2, 4'd3: c = 2'd1;
			4'd4, 4'd5: c = 2'd2;
			4'd6, 4'd7: c = 2'd3;
			default:    c = 2'd0;
		endcase
		return c;
	endfunction

	function automatic logic [1:0] word_code(input logic [6:0] w, input logic wide);
		logic [1:0] c;
		if (wide) begin
			if (w <= 7'd28)      c = 2'd0;
			else if (w <= 7'd31) c = 2'd1;
			else if (w <= 7'd35) c = 2'd2;
			else                 c = 2'd3;
		end else begin
			if (w <= 7'd13)      c = 2'd0;
			else if (w <= 7'd15) c = 2'd1;
			else if (w <= 7'd17) c = 2'd2;
			else                 c = 2'd3;
		end
		return c;
	endfunction

endpackage

@@ design/hamming_tuple_histogram_top.sv @@
// ----------------------------------------------------------------------------
// hamming_tuple_histogram_top
// Read result: a read waits in the front item, behind an earlier word's digits,
// passes the rd_s1 stage into the result queue that drives out_valid; reads
// issue one a cycle while the queue has room. Throughput: one digit per cycle
// through the histogram read port; a word gives one digit, or 4 / 8 in byte
// mode (32 / 64-bit words). Reset: clears all 2^(CODE_BITS*TUPLE_DIGITS) RAM
// entries (262144 by default), one a cycle, in_stall high; config writes taken.
// ----------------------------------------------------------------------------
module hamming_tuple_histogram_top
	import hth_pkg::*;
#(
	parameter int CODE_BITS    = 2,
	parameter int TUPLE_DIGITS = 9,
	parameter int COUNT_WIDTH  = 40
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  hth_in_t                   in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output hth_out_t                  out_data,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int WIN_BITS  = CODE_BITS * TUPLE_DIGITS;
	localparam int DEPTH     = 1 << WIN_BITS;
	localparam int SEEN_BITS = $clog2(TUPLE_DIGITS + 1);

	// configuration
	logic [1:0] mode_q;
	logic       wide_q;

	// stream state
	logic [WIN_BITS-1:0]  win_q;
	logic [SEEN_BITS-1:0] seen_q;
	logic [7:0]           gather_q;
	logic [2:0]           gcnt_q;

	// front item
	logic                fr_valid_q;
	hth_kind_t           fr_kind_q;
	logic [3:0]          fr_left_q;
	logic [2:0]          fr_sel_q;
	logic                fr_wide_q;
	logic [WIN_BITS-1:0] fr_bin_q;
	logic [3:0]          pc_q [8];

	// clearing pass
	logic                clr_busy_q;
	logic [WIN_BITS-1:0] clr_addr_q;

	// memory pipeline
	logic [COUNT_WIDTH-1:0] hist_mem [DEPTH];
	logic [COUNT_WIDTH-1:0] rdata_s1;
	logic                   inc_s1;
	logic                   rd_s1;
	logic [WIN_BITS-1:0]    addr_s1;
	logic                   wr_valid_q;
	logic [WIN_BITS-1:0]    wr_addr_q;
	logic [COUNT_WIDTH-1:0] wr_data_q;

	// result queue
	hth_out_t   fifo_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] fcnt_q;

	logic                   in_acc;
	logic                   can_rd;
	logic                   issue_rd;
	logic                   issue_dig;
	logic                   fr_free;
	logic                   cnt_dig;
	logic [6:0]             pc_sum;
	logic [3:0]             pc_sel;
	logic [1:0]             code;
	logic [WIN_BITS-1:0]    rd_addr;
	logic                   fwd;
	logic [COUNT_WIDTH-1:0] cur;
	logic [COUNT_WIDTH-1:0] nxt;
	logic                   mem_we;
	logic [WIN_BITS-1:0]    mem_waddr;
	logic [COUNT_WIDTH-1:0] mem_wdata;
	logic                   pop;
	logic [63:0]            word;
	logic [7:0]             g_new;
	logic [3:0]             pc_in [8];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BYTES;
			wide_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_SOURCE_MODE) mode_q <= cfg_data[1:0];
			if (cfg_index == REG_WORD_SIZE)   wide_q <= cfg_data[0];
		end
	end

	// handshake and issue
	assign can_rd    = (fcnt_q + {1'b0, rd_s1}) < (2'd2 + {1'b0, pop});
	assign issue_rd  = fr_valid_q && (fr_kind_q == KIND_READ) && can_rd;
	assign issue_dig = fr_valid_q && (fr_kind_q != KIND_READ);
	assign fr_free   = !fr_valid_q || issue_rd || (issue_dig && (fr_left_q == 4'd1));
	assign in_stall  = clr_busy_q || !fr_free;
	assign in_acc    = in_valid && !in_stall;

	// capture of a new word
	assign word  = wide_q ? in_data.sample : {32'b0, in_data.sample[31:0]};
	assign g_new = gather_q | (8'(in_data.sample[0]) << gcnt_q);

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			pc_in[i] = popcount8(word[8*i +: 8]);
		end
		if (mode_q == MODE_GATHER) pc_in[0] = popcount8(g_new);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_valid_q <= 1'b0;
			gather_q   <= '0;
			gcnt_q     <= '0;
		end else if (in_acc) begin
			if (in_data.op == OP_READ) begin
				fr_valid_q <= 1'b1;
			end else begin
				case (mode_q)
					MODE_WORD, MODE_BYTES, MODE_LOW: fr_valid_q <= 1'b1;
					default: begin
						fr_valid_q <= (gcnt_q == 3'd7);
						gather_q   <= (gcnt_q == 3'd7) ? 8'd0 : g_new;
						gcnt_q     <= gcnt_q + 3'd1;
					end
				endcase
			end
		end else if (fr_free) begin
			fr_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			fr_bin_q  <= WIN_BITS'(in_data.bin_index);
			fr_wide_q <= wide_q;
			fr_sel_q  <= '0;
			for (int i = 0; i < 8; i++) pc_q[i] <= pc_in[i];
			if (in_data.op == OP_READ) begin
				fr_kind_q <= KIND_READ;
				fr_left_q <= 4'd1;
			end else begin
				case (mode_q)
					MODE_WORD: begin
						fr_kind_q <= KIND_WORD;
						fr_left_q <= 4'd1;
					end
					MODE_BYTES: begin
						fr_kind_q <= KIND_BYTES;
						fr_left_q <= wide_q ? 4'd8 : 4'd4;
					end
					default: begin
						fr_kind_q <= KIND_BYTES;
						fr_left_q <= 4'd1;
					end
				endcase
			end
		end else if (issue_dig) begin
			fr_left_q <= fr_left_q - 4'd1;
			fr_sel_q  <= fr_sel_q + 3'd1;
		end
	end

	// digit and window
	always_comb begin
		pc_sum = '0;
		for (int i = 0; i < 8; i++) begin
			pc_sum = pc_sum + 7'(pc_q[i]);
		end
	end

	assign pc_sel  = pc_q[fr_sel_q];
	assign code    = (fr_kind_q == KIND_WORD) ? word_code(pc_sum, fr_wide_q) : byte_code(pc_sel);
	assign cnt_dig = issue_dig && (seen_q == SEEN_BITS'(TUPLE_DIGITS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			seen_q <= '0;
		end else if (issue_dig) begin
			win_q <= {win_q[WIN_BITS-CODE_BITS-1:0], code[CODE_BITS-1:0]};
			if (!cnt_dig) seen_q <= seen_q + SEEN_BITS'(1);
		end
	end

	// histogram RAM, read-modify-write with one-deep forwarding
	assign rd_addr = issue_rd ? fr_bin_q : win_q;
	assign fwd     = wr_valid_q && (wr_addr_q == addr_s1);
	assign cur     = fwd ? wr_data_q : rdata_s1;
	assign nxt     = (&cur) ? cur : cur + COUNT_WIDTH'(1);

	assign mem_we    = clr_busy_q || inc_s1;
	assign mem_waddr = clr_busy_q ? clr_addr_q : addr_s1;
	assign mem_wdata = clr_busy_q ? '0 : nxt;

	always_ff @(posedge clk) begin
		if (mem_we) hist_mem[mem_waddr] <= mem_wdata;
		rdata_s1 <= hist_mem[rd_addr];
		addr_s1  <= rd_addr;
		wr_addr_q <= addr_s1;
		wr_data_q <= nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_s1     <= 1'b0;
			rd_s1      <= 1'b0;
			wr_valid_q <= 1'b0;
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			inc_s1     <= cnt_dig;
			rd_s1      <= issue_rd;
			wr_valid_q <= inc_s1;
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + WIN_BITS'(1);
				if (&clr_addr_q) clr_busy_q <= 1'b0;
			end
		end
	end

	// result queue
	assign out_valid = (fcnt_q != 2'd0);
	assign out_data  = fifo_q[rptr_q];
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (rd_s1) begin
			fifo_q[wptr_q].bin_count <= 40'(cur);
			fifo_q[wptr_q].bin_echo  <= 18'(addr_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fcnt_q <= '0;
		end else begin
			if (rd_s1) wptr_q <= !wptr_q;
			if (pop)   rptr_q <= !rptr_q;
			fcnt_q <= fcnt_q + {1'b0, rd_s1} - {1'b0, pop};
		end
	end

`ifndef NO_ASSERTIONS
	a_no_clear_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !inc_s1 && !rd_s1)
		else $error("histogram update during clearing pass");

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1 |-> fcnt_q != 2'd2)
		else $error("read result with full result queue");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q != 2'd3)
		else $error("result queue overflow");

	a_fwd_follows_write: assert property (@(posedge clk) disable iff (!arst_n)
		inc_s1 |=> wr_valid_q && wr_addr_q == $past(addr_s1))
		else $error("forwarding register missed a histogram write");
`endif

endmodule
